>>> rtl/core/vcfc_pkg.sv
// Package: types, codes and sizes shared by the voxel chunk face culler.
package vcfc_pkg;

  localparam int CHUNK_EDGE   = 16;
  localparam int BLOCK_TYPES  = 64;
  localparam int SIDES        = 6;
  localparam int VOXELS       = CHUNK_EDGE * CHUNK_EDGE * CHUNK_EDGE;
  localparam int FACE_CELLS   = CHUNK_EDGE * CHUNK_EDGE;
  localparam int BORDER_CELLS = SIDES * FACE_CELLS;
  localparam int VADDR_W      = 12;
  localparam int BADDR_W      = 11;
  localparam int ID_W         = 6;

  typedef enum logic [2:0] {
    REQ_SET      = 3'd0,
    REQ_GET      = 3'd1,
    REQ_FILL_ALL = 3'd2,
    REQ_FILL_LYR = 3'd3,
    REQ_FILL_COL = 3'd4,
    REQ_BORDER   = 3'd5,
    REQ_CULL     = 3'd6,
    REQ_RSVD     = 3'd7
  } req_t;

  typedef enum logic [0:0] {
    CFG_OPAQUE_TYPES = 1'b0,
    CFG_NB_PRESENT   = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_CULL,
    ST_DONE
  } ctl_state_t;

  typedef enum logic [2:0] {
    K_NONE,
    K_CENTER,
    K_VOXEL,
    K_BORDER,
    K_OPAQUE
  } rd_kind_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic [3:0] pos_x;
    logic [3:0] pos_y;
    logic [3:0] pos_z;
    logic [3:0] range_from;
    logic [3:0] range_to;
    logic [5:0] block_id;
    logic [2:0] border_side;
    logic [3:0] border_u;
    logic [3:0] border_v;
    logic       border_bit;
    logic       pass_end;
  } in_item_t;

  typedef struct packed {
    logic [5:0] read_id;
    logic [5:0] face_mask;
    logic       all_air;
    logic       mesh_dirty;
    logic       status;
  } out_item_t;

  typedef struct packed {
    logic load_req;
    logic exec;
    logic sweep_step;
    logic cull_step;
    logic clr_step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic       sweep_last;
    logic       cull_last;
    logic       clr_last;
    logic       out_free;
  } dp_stat_t;

endpackage

>>> rtl/core/vcfc_datapath.sv
// Datapath: voxel and border stores, flags, config registers, cull evaluation, output register.
module vcfc_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  vcfc_pkg::dp_cmd_t  cmd,
  output vcfc_pkg::dp_stat_t stat,
  input  vcfc_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output vcfc_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  input  logic               cfg_index,
  input  logic [63:0]        cfg_data
);
  import vcfc_pkg::*;

  logic [ID_W-1:0] voxel_mem [0:VOXELS-1];
  logic            border_mem [0:BORDER_CELLS-1];

  in_item_t        req_r;
  logic [VADDR_W-1:0] cnt_r;
  logic            air_r, dirty_r;
  logic [63:0]     opq_r;
  logic [5:0]      nbp_r;
  logic [5:0]      mask_r, mask_nxt;
  rd_kind_t        kind_r, kind_nxt;
  logic [2:0]      kside_r;
  logic            out_valid_r;
  out_item_t       out_r, out_nxt;
  logic [ID_W-1:0] vox_q;
  logic            bd_q;

  logic [VADDR_W-1:0] center, sweep_addr, nb_addr, vwa, vra;
  logic [BADDR_W-1:0] bwa, bra;
  logic [ID_W-1:0]    vwd;
  logic               vwe, bwe, bwd;
  logic [3:0]         col_h, bu, bv;
  logic               col_empty, nb_inside, vox_opq;
  logic [2:0]         step, ns;

  assign center    = {req_r.pos_x, req_r.pos_y, req_r.pos_z};
  assign col_h     = req_r.range_from + cnt_r[3:0];
  assign col_empty = req_r.range_to < req_r.range_from;
  assign step      = cnt_r[2:0];
  assign ns        = step - 3'd1;
  assign vox_opq   = (vox_q == ID_W'(1)) || opq_r[vox_q];

  always_comb begin
    case (req_r.req_type)
      REQ_FILL_LYR: sweep_addr = {cnt_r[7:4], req_r.pos_y, cnt_r[3:0]};
      REQ_FILL_COL: sweep_addr = {req_r.pos_x, col_h, req_r.pos_z};
      default:      sweep_addr = cnt_r;
    endcase
  end

  // neighbour of the center on side ns
  always_comb begin
    nb_inside = 1'b0;
    nb_addr   = center;
    bu        = req_r.pos_x;
    bv        = req_r.pos_z;
    case (ns)
      3'd0: begin
        nb_inside = req_r.pos_y != 4'hf;
        nb_addr   = {req_r.pos_x, req_r.pos_y + 4'd1, req_r.pos_z};
      end
      3'd1: begin
        nb_inside = req_r.pos_y != 4'h0;
        nb_addr   = {req_r.pos_x, req_r.pos_y - 4'd1, req_r.pos_z};
      end
      3'd2: begin
        nb_inside = req_r.pos_x != 4'h0;
        nb_addr   = {req_r.pos_x - 4'd1, req_r.pos_y, req_r.pos_z};
        bu        = req_r.pos_y;
      end
      3'd3: begin
        nb_inside = req_r.pos_x != 4'hf;
        nb_addr   = {req_r.pos_x + 4'd1, req_r.pos_y, req_r.pos_z};
        bu        = req_r.pos_y;
      end
      3'd4: begin
        nb_inside = req_r.pos_z != 4'hf;
        nb_addr   = {req_r.pos_x, req_r.pos_y, req_r.pos_z + 4'd1};
        bv        = req_r.pos_y;
      end
      3'd5: begin
        nb_inside = req_r.pos_z != 4'h0;
        nb_addr   = {req_r.pos_x, req_r.pos_y, req_r.pos_z - 4'd1};
        bv        = req_r.pos_y;
      end
      default: ;
    endcase
  end

  always_comb begin
    vwe = 1'b0;
    vwa = center;
    vwd = req_r.block_id;
    bwe = 1'b0;
    bwa = {req_r.border_side, req_r.border_u, req_r.border_v};
    bwd = req_r.border_bit;
    if (cmd.clr_step) begin
      vwe = 1'b1;
      vwa = cnt_r;
      vwd = '0;
      bwe = cnt_r < VADDR_W'(BORDER_CELLS);
      bwa = cnt_r[BADDR_W-1:0];
      bwd = 1'b0;
    end else if (cmd.sweep_step) begin
      vwe = !((req_r.req_type == REQ_FILL_COL) && col_empty);
      vwa = sweep_addr;
    end else if (cmd.exec) begin
      vwe = req_r.req_type == REQ_SET;
      bwe = (req_r.req_type == REQ_BORDER) && (req_r.border_side < 3'(SIDES));
    end
  end

  assign vra = (cmd.cull_step && step != 3'd0 && step != 3'd7) ? nb_addr : center;
  assign bra = {ns, bu, bv};

  always_ff @(posedge clk) begin
    if (vwe) voxel_mem[vwa] <= vwd;
    vox_q <= voxel_mem[vra];
  end

  always_ff @(posedge clk) begin
    if (bwe) border_mem[bwa] <= bwd;
    bd_q <= border_mem[bra];
  end

  // cull: issue one read per step, evaluate the previous one
  always_comb begin
    mask_nxt = mask_r;
    kind_nxt = kind_r;
    if (cmd.load_req) begin
      kind_nxt = K_NONE;
    end else if (cmd.cull_step) begin
      if (step == 3'd0) mask_nxt = '0;
      case (kind_r)
        K_VOXEL:  mask_nxt[kside_r] = !vox_opq;
        K_BORDER: mask_nxt[kside_r] = !bd_q;
        K_OPAQUE: mask_nxt[kside_r] = 1'b0;
        default:  ;
      endcase
      if (step == 3'd0)      kind_nxt = K_CENTER;
      else if (step == 3'd7) kind_nxt = K_NONE;
      else if (nb_inside)    kind_nxt = K_VOXEL;
      else if (nbp_r[ns])    kind_nxt = K_BORDER;
      else                   kind_nxt = K_OPAQUE;
    end
  end

  always_comb begin
    out_nxt.read_id    = ((req_r.req_type == REQ_GET) || (req_r.req_type == REQ_CULL)) ?
                         vox_q : '0;
    out_nxt.face_mask  = ((req_r.req_type == REQ_CULL) && !air_r && vox_q > ID_W'(1)) ?
                         mask_r : '0;
    out_nxt.all_air    = air_r;
    out_nxt.mesh_dirty = dirty_r;
    out_nxt.status     = req_r.req_type == REQ_RSVD;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) req_r <= in_data;
    if (cmd.finish) out_r <= out_nxt;
    mask_r  <= mask_nxt;
    if (cmd.cull_step) kside_r <= ns;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      air_r       <= 1'b1;
      dirty_r     <= 1'b1;
      opq_r       <= 64'd2;
      nbp_r       <= '0;
      kind_r      <= K_NONE;
      out_valid_r <= 1'b0;
    end else begin
      kind_r <= kind_nxt;
      if (cmd.load_req) cnt_r <= '0;
      else if (cmd.clr_step || cmd.sweep_step || cmd.cull_step) cnt_r <= cnt_r + 1'b1;
      if (cmd.exec) begin
        case (req_r.req_type)
          REQ_SET, REQ_FILL_LYR, REQ_FILL_COL: begin
            if (req_r.block_id != '0) air_r <= 1'b0;
            dirty_r <= 1'b1;
          end
          REQ_FILL_ALL: begin
            air_r   <= req_r.block_id == '0;
            dirty_r <= 1'b1;
          end
          REQ_CULL: if (req_r.pass_end) dirty_r <= 1'b0;
          default: ;
        endcase
      end
      if (cfg_valid) begin
        case (cfg_index)
          CFG_OPAQUE_TYPES: opq_r <= cfg_data;
          CFG_NB_PRESENT:   nbp_r <= cfg_data[5:0];
          default: ;
        endcase
      end
      if (cmd.finish)      out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    stat.req_type = req_r.req_type;
    case (req_r.req_type)
      REQ_FILL_LYR: stat.sweep_last = cnt_r[7:0] == 8'hff;
      REQ_FILL_COL: stat.sweep_last = col_empty || (col_h == req_r.range_to);
      default:      stat.sweep_last = &cnt_r;
    endcase
    stat.cull_last = step == 3'd7;
    stat.clr_last  = &cnt_r;
    stat.out_free  = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> rtl/core/vcfc_ctrl.sv
// Controller: request sequencing state machine for the face culler.
module vcfc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  vcfc_pkg::dp_stat_t stat,
  output vcfc_pkg::dp_cmd_t  cmd
);
  import vcfc_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        case (stat.req_type)
          REQ_FILL_ALL, REQ_FILL_LYR, REQ_FILL_COL: state_nxt = ST_SWEEP;
          REQ_CULL: state_nxt = ST_CULL;
          default:  state_nxt = ST_DONE;
        endcase
      end
      ST_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (stat.sweep_last) state_nxt = ST_DONE;
      end
      ST_CULL: begin
        cmd.cull_step = 1'b1;
        if (stat.cull_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

`ifndef SYNTHESIS
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !cmd.load_req) else $error("request taken during clear");
  a_finish_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> stat.out_free) else $error("result overwrites pending output");
  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && stat.out_free) |=> state_r == ST_IDLE)
    else $error("done state did not release");
  a_exec_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_req |=> state_r == ST_EXEC) else $error("accepted request not executed");
`endif

endmodule

>>> rtl/core/voxel_chunk_face_culler_top.sv
// Top level: voxel chunk face culler, controller plus datapath.
// One request at a time: input stalls from acceptance until the result enters the output register.
// The cull is sequenced by the single voxel store read port: center, then the six neighbours.
// Fill time is one store write per cycle. Results wait in an output register.
// Synchronous active-low reset; afterwards a clearing pass over all 4096 voxels stalls input.
module voxel_chunk_face_culler_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  vcfc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output vcfc_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [63:0]         cfg_data
);
  import vcfc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  vcfc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  vcfc_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

>>> tb/voxel_chunk_face_culler_top_tb.sv
// Testbench for voxel_chunk_face_culler_top: directed table plus random requests, predictor checked.
`timescale 1ns / 1ps

module voxel_chunk_face_culler_top_tb;
  import vcfc_pkg::*;

  localparam int LIMIT = 1500000;

  typedef struct {
    in_item_t  req;
    bit        typed;
    out_item_t want;
  } row_t;

  typedef struct {
    bit        typed;
    out_item_t want;
  } hint_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [63:0] cfg_data;

  logic [5:0]  voxels [VOXELS];
  bit          borders [BORDER_CELLS];
  bit          air_q, dirty_q;
  logic [63:0] opaque_q;
  logic [5:0]  present_q;

  out_item_t   result_q [$];
  hint_t       hint_q [$];
  row_t        rows [$];
  int          errors;
  int          cycles;
  int          tx_idle, rx_idle;

  voxel_chunk_face_culler_top DUT (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) out_stall <= ($urandom_range(99) < rx_idle);

  function automatic int vaddr(int x, int y, int z);
    return (x * CHUNK_EDGE + y) * CHUNK_EDGE + z;
  endfunction

  function automatic bit id_opaque(logic [5:0] id);
    return (id == 6'd1) || opaque_q[id];
  endfunction

  function automatic bit side_blocked(int x, int y, int z, int dx, int dy, int dz, int s);
    int nx, ny, nz, u, v;
    nx = x + dx;
    ny = y + dy;
    nz = z + dz;
    if (nx >= 0 && nx < CHUNK_EDGE && ny >= 0 && ny < CHUNK_EDGE &&
        nz >= 0 && nz < CHUNK_EDGE)
      return id_opaque(voxels[vaddr(nx, ny, nz)]);
    if (!present_q[s]) return 1'b1;
    if (s <= 1) begin
      u = x; v = z;
    end else if (s <= 3) begin
      u = y; v = z;
    end else begin
      u = x; v = y;
    end
    return borders[s * FACE_CELLS + u * CHUNK_EDGE + v];
  endfunction

  function automatic out_item_t apply_request(in_item_t t);
    out_item_t r;
    int x, y, z;
    x = t.pos_x;
    y = t.pos_y;
    z = t.pos_z;
    r = '0;
    case (req_t'(t.req_type))
      REQ_SET: begin
        voxels[vaddr(x, y, z)] = t.block_id;
        if (t.block_id != 0) air_q = 1'b0;
        dirty_q = 1'b1;
      end
      REQ_GET: r.read_id = voxels[vaddr(x, y, z)];
      REQ_FILL_ALL: begin
        foreach (voxels[i]) voxels[i] = t.block_id;
        air_q = (t.block_id == 0);
        dirty_q = 1'b1;
      end
      REQ_FILL_LYR: begin
        for (int i = 0; i < CHUNK_EDGE; i++)
          for (int j = 0; j < CHUNK_EDGE; j++) voxels[vaddr(i, y, j)] = t.block_id;
        if (t.block_id != 0) air_q = 1'b0;
        dirty_q = 1'b1;
      end
      REQ_FILL_COL: begin
        for (int h = t.range_from; h <= t.range_to; h++) voxels[vaddr(x, h, z)] = t.block_id;
        if (t.block_id != 0) air_q = 1'b0;
        dirty_q = 1'b1;
      end
      REQ_BORDER:
        if (t.border_side < SIDES)
          borders[t.border_side * FACE_CELLS + t.border_u * CHUNK_EDGE + t.border_v] =
            t.border_bit;
      REQ_CULL: begin
        r.read_id = voxels[vaddr(x, y, z)];
        if (!air_q && r.read_id != 0 && r.read_id != 1) begin
          r.face_mask[0] = !side_blocked(x, y, z, 0, 1, 0, 0);
          r.face_mask[1] = !side_blocked(x, y, z, 0, -1, 0, 1);
          r.face_mask[2] = !side_blocked(x, y, z, -1, 0, 0, 2);
          r.face_mask[3] = !side_blocked(x, y, z, 1, 0, 0, 3);
          r.face_mask[4] = !side_blocked(x, y, z, 0, 0, 1, 4);
          r.face_mask[5] = !side_blocked(x, y, z, 0, 0, -1, 5);
        end
        if (t.pass_end) dirty_q = 1'b0;
      end
      default: r.status = 1'b1;
    endcase
    r.all_air = air_q;
    r.mesh_dirty = dirty_q;
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk) begin
    out_item_t p;
    hint_t h;
    if (rst_n && in_valid && !in_stall) begin
      p = apply_request(in_data);
      h = hint_q.pop_front();
      result_q.push_back(h.typed ? h.want : p);
    end
    if (rst_n && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        report("unexpected transaction", out_data, 0);
      end else begin
        p = result_q.pop_front();
        if (out_data.read_id !== p.read_id) report("read_id", out_data.read_id, p.read_id);
        if (out_data.face_mask !== p.face_mask)
          report("face_mask", out_data.face_mask, p.face_mask);
        if (out_data.all_air !== p.all_air) report("all_air", out_data.all_air, p.all_air);
        if (out_data.mesh_dirty !== p.mesh_dirty)
          report("mesh_dirty", out_data.mesh_dirty, p.mesh_dirty);
        if (out_data.status !== p.status) report("status", out_data.status, p.status);
      end
    end
  end

  function automatic in_item_t mk_req(req_t k, int x, int y, int z, int from, int to, int id,
                                      int side, int u, int v, int b, int pend);
    in_item_t t;
    t.req_type = k;
    t.pos_x = 4'(x);
    t.pos_y = 4'(y);
    t.pos_z = 4'(z);
    t.range_from = 4'(from);
    t.range_to = 4'(to);
    t.block_id = 6'(id);
    t.border_side = 3'(side);
    t.border_u = 4'(u);
    t.border_v = 4'(v);
    t.border_bit = 1'(b);
    t.pass_end = 1'(pend);
    return t;
  endfunction

  function automatic out_item_t mk_res(int id, int mask, int air, int dirty, int st);
    out_item_t r;
    r.read_id = 6'(id);
    r.face_mask = 6'(mask);
    r.all_air = 1'(air);
    r.mesh_dirty = 1'(dirty);
    r.status = 1'(st);
    return r;
  endfunction

  task automatic add_row(in_item_t t, bit typed = 0, out_item_t want = '0);
    row_t r;
    r.req = t;
    r.typed = typed;
    r.want = want;
    rows.push_back(r);
  endtask

  task automatic send(in_item_t t, bit typed, out_item_t want);
    hint_t h;
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    h.typed = typed;
    h.want = want;
    hint_q.push_back(h);
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_OPAQUE_TYPES) opaque_q = val;
    else present_q = val[5:0];
    @(posedge clk);
  endtask

  function automatic logic [3:0] pick_coord();
    int c;
    c = $urandom_range(7);
    if (c < 3) return 4'(c);
    if (c < 6) return 4'(10 + c);
    return 4'($urandom_range(15));
  endfunction

  function automatic in_item_t rand_req();
    in_item_t t;
    int roll;
    t = in_item_t'({$urandom, $urandom});
    roll = $urandom_range(999);
    if (roll < 8) t.req_type = REQ_FILL_ALL;
    else if (roll < 35) t.req_type = REQ_FILL_LYR;
    else if (roll < 110) t.req_type = REQ_FILL_COL;
    else if (roll < 400) t.req_type = REQ_SET;
    else if (roll < 500) t.req_type = REQ_GET;
    else if (roll < 640) t.req_type = REQ_BORDER;
    else if (roll < 980) t.req_type = REQ_CULL;
    else t.req_type = REQ_RSVD;
    if ($urandom_range(3) != 0) begin
      t.pos_x = pick_coord();
      t.pos_y = pick_coord();
      t.pos_z = pick_coord();
      t.border_u = pick_coord();
      t.border_v = pick_coord();
    end
    if (t.req_type == REQ_BORDER && $urandom_range(9) != 0)
      t.border_side = 3'($urandom_range(5));
    if (t.req_type == REQ_CULL) t.pass_end = ($urandom_range(9) == 0);
    if ($urandom_range(2) == 0) t.block_id = 6'($urandom_range(4));
    return t;
  endfunction

  initial begin
    logic [63:0] opq_set [6];
    logic [5:0]  nbp_set [6];
    errors = 0;
    cycles = 0;
    tx_idle = 9;
    rx_idle = 66;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    out_stall <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_OPAQUE_TYPES;
    cfg_data <= '0;
    foreach (voxels[i]) voxels[i] = '0;
    foreach (borders[i]) borders[i] = 1'b0;
    air_q = 1'b1;
    dirty_q = 1'b1;
    opaque_q = 64'd2;
    present_q = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    add_row(mk_req(REQ_GET, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, mk_res(0, 0, 1, 1, 0));
    add_row(mk_req(REQ_CULL, 15, 15, 15, 0, 0, 0, 0, 0, 0, 0, 1), 1, mk_res(0, 0, 1, 0, 0));
    add_row(mk_req(REQ_RSVD, 15, 15, 15, 15, 15, 63, 7, 15, 15, 1, 1), 1,
            mk_res(0, 0, 1, 0, 1));
    add_row(mk_req(REQ_SET, 0, 0, 0, 0, 0, 63, 0, 0, 0, 0, 0), 1, mk_res(0, 0, 0, 1, 0));
    add_row(mk_req(REQ_GET, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, mk_res(63, 0, 0, 1, 0));
    add_row(mk_req(REQ_CULL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk_req(REQ_SET, 15, 15, 15, 0, 0, 1, 0, 0, 0, 0, 0), 1, mk_res(0, 0, 0, 1, 0));
    add_row(mk_req(REQ_CULL, 15, 15, 15, 0, 0, 0, 0, 0, 0, 0, 1), 1, mk_res(1, 0, 0, 0, 0));
    for (int s = 0; s < 8; s++)
      add_row(mk_req(REQ_BORDER, 0, 0, 0, 0, 0, 0, s, 15, 15, 1, 0));
    add_row(mk_req(REQ_FILL_COL, 3, 0, 4, 10, 2, 5, 0, 0, 0, 0, 0));
    add_row(mk_req(REQ_FILL_COL, 3, 0, 4, 0, 15, 9, 0, 0, 0, 0, 0));
    add_row(mk_req(REQ_CULL, 3, 7, 4, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk_req(REQ_FILL_LYR, 0, 15, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk_req(REQ_FILL_LYR, 0, 0, 0, 0, 0, 62, 0, 0, 0, 0, 0));
    add_row(mk_req(REQ_FILL_ALL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, mk_res(0, 0, 1, 1, 0));
    add_row(mk_req(REQ_CULL, 5, 5, 5, 0, 0, 0, 0, 0, 0, 0, 1), 1, mk_res(0, 0, 1, 0, 0));
    add_row(mk_req(REQ_FILL_ALL, 0, 0, 0, 0, 0, 63, 0, 0, 0, 0, 0), 1, mk_res(0, 0, 0, 1, 0));
    add_row(mk_req(REQ_CULL, 0, 15, 0, 0, 0, 0, 0, 0, 0, 0, 0));

    foreach (rows[i]) send(rows[i].req, rows[i].typed, rows[i].want);
    drain();

    opq_set = '{64'hFFFF_FFFF_FFFF_FFFF, 64'd0, {$urandom, $urandom}, 64'd2,
                {$urandom, $urandom}, 64'hAAAA_5555_F0F0_0F0F};
    nbp_set = '{6'd63, 6'd0, 6'h2A, 6'd63, 6'($urandom), 6'h15};
    for (int ph = 0; ph < 6; ph++) begin
      tx_idle = (ph < 2) ? 9 : (ph < 4) ? 66 : 0;
      rx_idle = (ph < 2) ? 66 : (ph < 4) ? 9 : 0;
      write_reg(CFG_OPAQUE_TYPES, opq_set[ph]);
      write_reg(CFG_NB_PRESENT, {58'd0, nbp_set[ph]});
      for (int n = 0; n < 65; n++) send(rand_req(), 0, '0);
      drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

>>> files.f
rtl/core/vcfc_pkg.sv
rtl/core/vcfc_datapath.sv
rtl/core/vcfc_ctrl.sv
rtl/core/voxel_chunk_face_culler_top.sv
tb/voxel_chunk_face_culler_top_tb.sv
